FILE: rtl/ott_pkg.sv
// ----------------------------------------------------------------------------
// ott_pkg
// shared constants, codes and entry layout of the order table tracker
// ----------------------------------------------------------------------------
`default_nettype none
package ott_pkg;
	localparam int SETS  = 4096;
	localparam int WAYS  = 4;
	localparam int SET_W = $clog2(SETS);
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	localparam logic [2:0] K_ADD  = 3'd0;
	localparam logic [2:0] K_ATTR = 3'd1;
	localparam logic [2:0] K_EXE  = 3'd2;
	localparam logic [2:0] K_EXP  = 3'd3;
	localparam logic [2:0] K_CAN  = 3'd4;
	localparam logic [2:0] K_DEL  = 3'd5;
	localparam logic [2:0] K_REP  = 3'd6;
	localparam logic [2:0] K_HID  = 3'd7;

	localparam logic [1:0] ST_NONE  = 2'd0;
	localparam logic [1:0] ST_TRADE = 2'd1;
	localparam logic [1:0] ST_DROP  = 2'd2;

	typedef struct packed {
		logic        valid;
		logic [63:0] reference;
		logic [15:0] locate;
		logic [31:0] owner;
		logic        side;
		logic [31:0] price;
		logic [31:0] remaining;
	} entry_t;

	typedef entry_t [WAYS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);
endpackage
`default_nettype wire

FILE: rtl/ott_ifs.sv
// ----------------------------------------------------------------------------
// ott channel interfaces
// message, result and configuration channels with valid and ready
// ----------------------------------------------------------------------------
`default_nettype none
interface itch_msg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] locate;
	logic [47:0] timestamp;
	logic [63:0] order_ref;
	logic [63:0] new_ref;
	logic [31:0] shares;
	logic [31:0] price;
	logic        side;
	logic [63:0] match_number;
	logic [31:0] participant;
	modport source (output valid, kind, locate, timestamp, order_ref, new_ref, shares,
		price, side, match_number, participant, input ready);
	modport sink (input valid, kind, locate, timestamp, order_ref, new_ref, shares,
		price, side, match_number, participant, output ready);
endinterface

interface itch_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] trade_id;
	logic [31:0] trade_owner;
	logic [15:0] trade_locate;
	logic        trade_side;
	logic [31:0] trade_quantity;
	logic [31:0] trade_price;
	logic [47:0] trade_time;
	modport source (output valid, status, trade_id, trade_owner, trade_locate, trade_side,
		trade_quantity, trade_price, trade_time, input ready);
	modport sink (input valid, status, trade_id, trade_owner, trade_locate, trade_side,
		trade_quantity, trade_price, trade_time, output ready);
endinterface

interface itch_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/ott_ram.sv
// ----------------------------------------------------------------------------
// ott_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module ott_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/itch_order_table_tracker.sv
// ----------------------------------------------------------------------------
// itch_order_table_tracker
// set-associative live order table driven by pre-parsed feed messages
// ----------------------------------------------------------------------------
// One result transaction per message. The accept cycle reads the set row from
// the table ram; the update state then updates the row, writes it back and
// loads the result register. A replace that hits with nonzero new shares makes
// a second read, of the new reference's set, before its second update. The
// update state waits while the result register still holds a transaction the
// receiver has not taken. After reset a clearing pass writes every set row once
// (4096 sets by default) before the first message is taken; configuration
// writes are taken at any time. The set is the low bits of the reference, so
// SETS is a power of two.
`default_nettype none
module itch_order_table_tracker (
	input wire logic   clk,
	input wire logic   arst_n,
	itch_msg_if.sink   msg,
	itch_res_if.source res,
	itch_cfg_if.sink   cfg
);
	import ott_pkg::*;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_EX   = 3'd2;
	localparam logic [2:0] S_RD2  = 3'd3;
	localparam logic [2:0] S_EX2  = 3'd4;

	logic [2:0]       state_q, state_n;
	logic [SET_W-1:0] clr_q;
	logic [31:0]      anon_q;

	logic [2:0]  kind_q;
	logic [15:0] locate_q;
	logic [47:0] ts_q;
	logic [63:0] ref_q, nref_q, match_q;
	logic [31:0] shares_q, price_q, part_q;
	logic        side_q;
	logic [15:0] o_loc_q;
	logic [31:0] o_own_q;
	logic        o_side_q;

	logic             we, re;
	logic [SET_W-1:0] waddr, raddr;
	row_t             row_rd, row_n;
	logic [ROW_W-1:0] rdata;

	logic        out_valid_q;
	logic        out_free, do_out, save_old;
	logic [1:0]  r_status;
	logic [63:0] r_id;
	logic [31:0] r_owner, r_qty, r_price;
	logic [15:0] r_loc;
	logic        r_side;
	logic [47:0] r_time;

	logic [63:0]      key;
	logic             hit, free;
	logic [WAY_W-1:0] hit_w, free_w, slot;
	logic [15:0]      st_loc;
	logic [31:0]      st_own;
	logic             st_side;

	assign msg.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free  = !out_valid_q || res.ready;
	assign re        = (msg.valid && msg.ready) || (state_q == S_RD2);
	assign raddr     = (state_q == S_RD2) ? nref_q[SET_W-1:0] : msg.order_ref[SET_W-1:0];
	assign row_rd    = row_t'(rdata);

	ott_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (ROW_W'(row_n)),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// way search
	assign key = (state_q == S_EX2) ? nref_q : ref_q;
	always_comb begin
		hit    = 1'b0;
		free   = 1'b0;
		hit_w  = '0;
		free_w = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row_rd[w].valid && row_rd[w].reference == key) begin
				hit   = 1'b1;
				hit_w = WAY_W'(w);
			end
			if (!row_rd[w].valid) begin
				free   = 1'b1;
				free_w = WAY_W'(w);
			end
		end
	end

	assign slot = hit ? hit_w : free_w;

	always_comb begin
		st_loc  = locate_q;
		st_own  = (kind_q == K_ATTR) ? part_q : anon_q;
		st_side = side_q;
		if (state_q == S_EX2) begin
			st_loc  = o_loc_q;
			st_own  = o_own_q;
			st_side = o_side_q;
		end
	end

	always_comb begin
		state_n  = state_q;
		row_n    = row_rd;
		we       = 1'b0;
		waddr    = ref_q[SET_W-1:0];
		do_out   = 1'b0;
		save_old = 1'b0;
		r_status = ST_NONE;
		r_id     = '0;
		r_owner  = '0;
		r_loc    = '0;
		r_side   = 1'b0;
		r_qty    = '0;
		r_price  = '0;
		r_time   = '0;
		unique case (state_q)
			S_CLR: begin
				row_n = '0;
				we    = 1'b1;
				waddr = clr_q;
				if (clr_q == SET_W'(SETS - 1)) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (msg.valid) begin
					state_n = S_EX;
				end
			end
			S_EX: begin
				if (out_free) begin
					do_out  = 1'b1;
					state_n = S_IDLE;
					unique case (kind_q)
						K_ADD, K_ATTR: begin
							if (shares_q != '0) begin
								if (hit || free) begin
									row_n[slot] = '{1'b1, ref_q, st_loc, st_own, st_side,
										price_q, shares_q};
									we = 1'b1;
								end else begin
									r_status = ST_DROP;
								end
							end
						end
						K_EXE, K_EXP, K_CAN: begin
							if (hit) begin
								if (kind_q != K_CAN) begin
									r_status = ST_TRADE;
									r_id     = match_q;
									r_owner  = row_rd[hit_w].owner;
									r_loc    = row_rd[hit_w].locate;
									r_side   = row_rd[hit_w].side;
									r_qty    = shares_q;
									r_price  = (kind_q == K_EXP && price_q != '0) ? price_q
										: row_rd[hit_w].price;
									r_time   = ts_q;
								end
								if (row_rd[hit_w].remaining <= shares_q) begin
									row_n[hit_w].valid = 1'b0;
								end else begin
									row_n[hit_w].remaining = row_rd[hit_w].remaining - shares_q;
								end
								we = 1'b1;
							end
						end
						K_DEL: begin
							if (hit) begin
								row_n[hit_w].valid = 1'b0;
								we = 1'b1;
							end
						end
						K_REP: begin
							if (hit) begin
								row_n[hit_w].valid = 1'b0;
								we       = 1'b1;
								save_old = 1'b1;
								if (shares_q != '0) begin
									do_out  = 1'b0;
									state_n = S_RD2;
								end
							end
						end
						K_HID: begin
							r_status = ST_TRADE;
							r_id     = match_q;
							r_owner  = anon_q;
							r_loc    = locate_q;
							r_side   = side_q;
							r_qty    = shares_q;
							r_price  = price_q;
							r_time   = ts_q;
						end
						default: begin
						end
					endcase
				end
			end
			S_RD2: begin
				state_n = S_EX2;
			end
			S_EX2: begin
				if (out_free) begin
					do_out  = 1'b1;
					state_n = S_IDLE;
					waddr   = nref_q[SET_W-1:0];
					if (hit || free) begin
						row_n[slot] = '{1'b1, nref_q, st_loc, st_own, st_side, price_q, shares_q};
						we = 1'b1;
					end else begin
						r_status = ST_DROP;
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			anon_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg.valid) begin
				anon_q <= cfg.data;
			end
			if (do_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// message and result payload
	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			kind_q   <= msg.kind;
			locate_q <= msg.locate;
			ts_q     <= msg.timestamp;
			ref_q    <= msg.order_ref;
			nref_q   <= msg.new_ref;
			shares_q <= msg.shares;
			price_q  <= msg.price;
			side_q   <= msg.side;
			match_q  <= msg.match_number;
			part_q   <= msg.participant;
		end
		if (save_old) begin
			o_loc_q  <= row_rd[hit_w].locate;
			o_own_q  <= row_rd[hit_w].owner;
			o_side_q <= row_rd[hit_w].side;
		end
		if (do_out) begin
			res.status         <= r_status;
			res.trade_id       <= r_id;
			res.trade_owner    <= r_owner;
			res.trade_locate   <= r_loc;
			res.trade_side     <= r_side;
			res.trade_quantity <= r_qty;
			res.trade_price    <= r_price;
			res.trade_time     <= r_time;
		end
	end

	assign res.valid = out_valid_q;

	a_accept_to_ex: assert property (@(posedge clk) disable iff (!arst_n)
		(msg.valid && msg.ready) |=> (state_q == S_EX))
		else $error("accepted message did not reach the update cycle");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_RD2) |-> !we)
		else $error("table write outside an update cycle");
	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !msg.ready)
		else $error("message taken during clearing pass");
	a_rep_second: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD2) |-> (kind_q == K_REP))
		else $error("second lookup for a message that is not a replace");
endmodule
`default_nettype wire
